// File: src/nzcr_pkg.sv
// Shared constants and controller/datapath interface types for the crossing-rate block.
`timescale 1ns / 1ps
`default_nettype none
package nzcr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 18;
    localparam int FREQ_W    = 26;
    localparam int FREQ_FRAC = 8;
    localparam int POS_W     = 36;
    localparam int COUNT_W   = 20;

    localparam logic [RATE_W-1:0]  RATE_RESET = 18'd4000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the incoming item
        logic frac_init;  // load the fraction divider
        logic frac_step;  // one restoring step of the fraction divider
        logic freq_init;  // load the frequency divider
        logic freq_step;  // one restoring step of the frequency divider
        logic commit;     // update the block state from the current item
        logic emit;       // load the output register
    } nzcr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cross_det;  // current item is a negative-going crossing
        logic last;       // current item closes the block
        logic have_edge;  // an earlier edge exists in this block
        logic out_free;   // output register can take a result this cycle
    } nzcr_status_t;

endpackage
`default_nettype wire

// File: src/nzcr_ctrl.sv
// Sequencing state machine for the crossing-rate block.
`timescale 1ns / 1ps
`default_nettype none
module nzcr_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  nzcr_pkg::nzcr_status_t status,
    output nzcr_pkg::nzcr_cmd_t    cmd
);
    import nzcr_pkg::*;

    localparam int NUM_W = RATE_W + FREQ_FRAC + FRACTION_BITS;
    localparam int CW    = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FRAC,
        ST_LOAD,
        ST_FREQ,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.cross_det)
                begin
                    cmd.frac_init = 1'b1;
                    cnt_next      = CW'(FRACTION_BITS);
                    state_next    = ST_FRAC;
                end
                else if (status.last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FRAC:
            begin
                cmd.frac_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = status.have_edge ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                cmd.freq_init = 1'b1;
                cnt_next      = CW'(NUM_W);
                state_next    = ST_FREQ;
            end
            ST_FREQ:
            begin
                cmd.freq_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: src/nzcr_dp.sv
// Datapath: block state, two restoring dividers and the output register.
`timescale 1ns / 1ps
`default_nettype none
module nzcr_dp #(
    parameter int MAX_SAMPLES_LOG2 = 20,
    parameter int FRACTION_BITS    = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  nzcr_pkg::nzcr_cmd_t                  cmd,
    output nzcr_pkg::nzcr_status_t               status,
    input  wire                                  cfg_wr_en,
    input  wire  [nzcr_pkg::RATE_W-1:0]          cfg_wr_data,
    input  wire  signed [nzcr_pkg::SAMPLE_W-1:0] sample,
    input  wire                                  block_end,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 crossing,
    output logic [nzcr_pkg::POS_W-1:0]           edge_position,
    output logic                                 interval_valid,
    output logic [nzcr_pkg::FREQ_W-1:0]          interval_frequency,
    output logic [nzcr_pkg::POS_W-1:0]           interval_midpoint,
    output logic [nzcr_pkg::COUNT_W-1:0]         interval_count,
    output logic                                 block_done
);
    import nzcr_pkg::*;

    localparam int MS    = MAX_SAMPLES_LOG2;
    localparam int FB    = FRACTION_BITS;
    localparam int EW    = MS + FB;
    localparam int NUM_W = RATE_W + FREQ_FRAC + FB;

    // configuration
    logic [RATE_W-1:0]   rate_reg;

    // current item
    logic [SAMPLE_W-1:0] cur_reg;
    logic                last_reg;

    // block state
    logic [SAMPLE_W-1:0] prev_sample_reg;
    logic                have_prev_reg;
    logic [MS-1:0]       idx_reg;
    logic [EW-1:0]       prev_edge_reg;
    logic                have_edge_reg;
    logic [COUNT_W-1:0]  count_reg;

    // fraction divider
    logic [SAMPLE_W:0]   frem_reg;
    logic [FB-1:0]       fq_reg;

    // frequency divider
    logic [EW-1:0]       d_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [EW:0]         qrem_reg;
    logic [NUM_W-1:0]    qq_reg;

    // output register
    logic                out_valid_reg;

    logic                cross_det;
    logic [SAMPLE_W:0]   den;
    logic [SAMPLE_W:0]   ft;
    logic                fge;
    logic [EW-1:0]       edge_cur;
    logic [EW:0]         qt;
    logic                qge;
    logic [EW:0]         edge_sum;
    logic [FREQ_W-1:0]   freq_sat;
    logic [COUNT_W-1:0]  count_new;
    logic [EW+POS_W-1:0] edge_ext;
    logic [EW+POS_W-1:0] mid_ext;

    assign cross_det = have_prev_reg && !prev_sample_reg[SAMPLE_W-1] && (|prev_sample_reg)
                       && cur_reg[SAMPLE_W-1];

    // a - b, positive on a crossing
    assign den = {prev_sample_reg[SAMPLE_W-1], prev_sample_reg}
               - {cur_reg[SAMPLE_W-1], cur_reg};
    assign ft  = {frem_reg[SAMPLE_W-1:0], 1'b0};
    assign fge = (ft >= den);

    // fraction is below one sample, so the edge is a plain concatenation
    assign edge_cur = {idx_reg, fq_reg};

    assign qt  = {qrem_reg[EW-1:0], num_reg[NUM_W-1]};
    assign qge = (qt >= {1'b0, d_reg});

    // zero spacing gives an all-ones quotient, which saturates as well
    assign freq_sat = (|qq_reg[NUM_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : qq_reg[FREQ_W-1:0];

    assign edge_sum = {1'b0, prev_edge_reg} + {1'b0, edge_cur};
    assign edge_ext = {{POS_W{1'b0}}, edge_cur};
    assign mid_ext  = {{POS_W{1'b0}}, edge_sum[EW:1]};

    always_comb
    begin
        count_new = count_reg;
        if (cross_det && have_edge_reg && (count_reg != COUNT_MAX))
        begin
            count_new = count_reg + 1'b1;
        end
    end

    assign status.cross_det = cross_det;
    assign status.last      = last_reg;
    assign status.have_edge = have_edge_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg        <= RATE_RESET;
            prev_sample_reg <= '0;
            have_prev_reg   <= 1'b0;
            idx_reg         <= '0;
            prev_edge_reg   <= '0;
            have_edge_reg   <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    prev_sample_reg <= '0;
                    have_prev_reg   <= 1'b0;
                    idx_reg         <= '0;
                    prev_edge_reg   <= '0;
                    have_edge_reg   <= 1'b0;
                    count_reg       <= '0;
                end
                else
                begin
                    prev_sample_reg <= cur_reg;
                    have_prev_reg   <= 1'b1;
                    idx_reg         <= idx_reg + 1'b1;
                    count_reg       <= count_new;
                    if (cross_det)
                    begin
                        prev_edge_reg <= edge_cur;
                        have_edge_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and divider registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg  <= sample;
            last_reg <= block_end;
        end
        if (cmd.frac_init)
        begin
            frem_reg <= {1'b0, prev_sample_reg};
            fq_reg   <= '0;
        end
        else if (cmd.frac_step)
        begin
            frem_reg <= fge ? (ft - den) : ft;
            fq_reg   <= {fq_reg[FB-2:0], fge};
        end
        if (cmd.freq_init)
        begin
            d_reg    <= edge_cur - prev_edge_reg;
            num_reg  <= {rate_reg, {(FREQ_FRAC + FB){1'b0}}};
            qrem_reg <= '0;
            qq_reg   <= '0;
        end
        else if (cmd.freq_step)
        begin
            qrem_reg <= qge ? (qt - {1'b0, d_reg}) : qt;
            qq_reg   <= {qq_reg[NUM_W-2:0], qge};
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            crossing           <= cross_det;
            edge_position      <= cross_det ? edge_ext[POS_W-1:0] : '0;
            interval_valid     <= cross_det && have_edge_reg;
            interval_frequency <= (cross_det && have_edge_reg) ? freq_sat : '0;
            interval_midpoint  <= (cross_det && have_edge_reg) ? mid_ext[POS_W-1:0] : '0;
            interval_count     <= count_new;
            block_done         <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: src/negative_zero_crossing_rate.sv
// Top level of the negative-going zero-crossing interval estimator.
// Usage:
//   Input channel (in_valid/in_ready, sample, block_end) takes one signed
//   sample per item; block_end marks the last sample of a block.
//   Output channel (out_valid/out_ready) carries at most one result per
//   input item: one for each negative-going crossing, and always one for the
//   last sample of a block (block_done = 1), after which the block state clears.
//   cfg_wr_en/cfg_wr_data write sample_rate; write only when idle.
// Sequencing:
//   A sample with no result is captured, checked and committed. A crossing
//   runs the one-bit-per-cycle fraction divider; a later crossing of a block
//   then loads and runs the one-bit-per-cycle frequency divider before the
//   result is emitted.
//   One item is worked on at a time; in_ready is high when the sequencer idles.
// Reset: rst_n is asynchronous and active low; sample_rate returns to 4000 Hz
//   and all block state clears.
// Stall: a finished result sits in the output register; the next item is
//   accepted meanwhile and waits only when its own result is ready to load.
`timescale 1ns / 1ps
`default_nettype none
module negative_zero_crossing_rate #(
    parameter int MAX_SAMPLES_LOG2 = 20,
    parameter int FRACTION_BITS    = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire  [nzcr_pkg::RATE_W-1:0]          cfg_wr_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  signed [nzcr_pkg::SAMPLE_W-1:0] sample,
    input  wire                                  block_end,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 crossing,
    output logic [nzcr_pkg::POS_W-1:0]           edge_position,
    output logic                                 interval_valid,
    output logic [nzcr_pkg::FREQ_W-1:0]          interval_frequency,
    output logic [nzcr_pkg::POS_W-1:0]           interval_midpoint,
    output logic [nzcr_pkg::COUNT_W-1:0]         interval_count,
    output logic                                 block_done
);
    import nzcr_pkg::*;

    nzcr_cmd_t    cmd;
    nzcr_status_t status;

    // sequencer: accept, check, divide, emit
    nzcr_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // block state, serial dividers, output register
    nzcr_dp #(
        .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .sample             (sample),
        .block_end          (block_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .crossing           (crossing),
        .edge_position      (edge_position),
        .interval_valid     (interval_valid),
        .interval_frequency (interval_frequency),
        .interval_midpoint  (interval_midpoint),
        .interval_count     (interval_count),
        .block_done         (block_done)
    );

endmodule
`default_nettype wire

// File: src/nzcr_checker.sv
// Port-level checks for the crossing-rate block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nzcr_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  in_valid,
    input wire                                  in_ready,
    input wire  signed [nzcr_pkg::SAMPLE_W-1:0] sample,
    input wire                                  block_end,
    input wire                                  out_valid,
    input wire                                  out_ready,
    input wire                                  crossing,
    input wire  [nzcr_pkg::POS_W-1:0]           edge_position,
    input wire                                  interval_valid,
    input wire  [nzcr_pkg::FREQ_W-1:0]          interval_frequency,
    input wire  [nzcr_pkg::POS_W-1:0]           interval_midpoint,
    input wire  [nzcr_pkg::COUNT_W-1:0]         interval_count,
    input wire                                  block_done
);
    import nzcr_pkg::*;

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(block_end))
        else $error("input item changed while waiting");

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_position)
            && $stable(interval_frequency) && $stable(interval_count))
        else $error("output item changed while stalled");

    // an interval needs a crossing
    a_ivalid_cross: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interval_valid |-> crossing)
        else $error("interval reported without a crossing");

    // only the block end may give an item without a crossing, and it carries no edge
    a_nocross_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !crossing |-> block_done && (edge_position == '0))
        else $error("item without crossing is not a clean block end");

    // no interval means zero frequency and midpoint
    a_noint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !interval_valid |->
            (interval_frequency == '0) && (interval_midpoint == '0))
        else $error("interval fields set without an interval");

endmodule

bind negative_zero_crossing_rate nzcr_checker u_nzcr_checker (.*);
`default_nettype wire

// File: sim/crossing_checker.sv
// Channel monitor, crossing-interval predictor and result comparison for the crossing-rate block.
`timescale 1ns / 1ps
module crossing_checker (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire  [nzcr_pkg::RATE_W-1:0]          cfg_wr_data,
    input  wire                                  in_valid,
    input  wire                                  in_ready,
    input  wire  signed [nzcr_pkg::SAMPLE_W-1:0] sample,
    input  wire                                  block_end,
    input  wire                                  out_valid,
    input  wire                                  out_ready,
    input  wire                                  crossing,
    input  wire  [nzcr_pkg::POS_W-1:0]           edge_position,
    input  wire                                  interval_valid,
    input  wire  [nzcr_pkg::FREQ_W-1:0]          interval_frequency,
    input  wire  [nzcr_pkg::POS_W-1:0]           interval_midpoint,
    input  wire  [nzcr_pkg::COUNT_W-1:0]         interval_count,
    input  wire                                  block_done,
    output int                                   fail_count,
    output int                                   pending
);
    import nzcr_pkg::*;

    localparam int              IDX_W     = 20;
    localparam int              FRAC_BITS = 16;
    localparam longint unsigned EDGE_MASK = (64'd1 << (IDX_W + FRAC_BITS)) - 64'd1;
    localparam longint unsigned FREQ_MAX  = (64'd1 << FREQ_W) - 64'd1;

    typedef struct packed {
        logic               crossing;
        logic [POS_W-1:0]   edge_pos;
        logic               ivalid;
        logic [FREQ_W-1:0]  freq;
        logic [POS_W-1:0]   mid;
        logic [COUNT_W-1:0] count;
        logic               done;
    } crossing_result_t;

    crossing_result_t expected_results[$];

    // shadow of the block state
    logic [RATE_W-1:0]          rate;
    logic signed [SAMPLE_W-1:0] last_sample;
    logic                       seen_sample;
    logic [IDX_W-1:0]           sample_pos;
    longint unsigned            last_edge;
    logic                       seen_edge;
    logic [COUNT_W-1:0]         intervals;
    int                         errors_seen;

    task automatic clear_block();
        last_sample = '0;
        seen_sample = 1'b0;
        sample_pos  = '0;
        last_edge   = 0;
        seen_edge   = 1'b0;
        intervals   = '0;
    endtask

    // Work out what one accepted sample produces and queue it
    task automatic track_sample(input logic signed [SAMPLE_W-1:0] cur, input logic closes);
        crossing_result_t r;
        logic             is_cross;
        int               hi;
        int               lo;
        longint unsigned  frac;
        longint unsigned  pos_now;
        longint unsigned  spacing;
        longint unsigned  quot;
        r        = '0;
        pos_now  = 0;
        is_cross = seen_sample && (last_sample > 0) && (cur < 0);
        if (is_cross)
        begin
            hi      = last_sample;
            lo      = cur;
            frac    = (longint'(hi) << FRAC_BITS) / longint'(hi - lo);
            pos_now = ((longint'(sample_pos) << FRAC_BITS) + frac) & EDGE_MASK;
            if (seen_edge)
            begin
                spacing = (pos_now - last_edge) & EDGE_MASK;
                if (spacing == 0)
                    quot = FREQ_MAX;
                else
                begin
                    quot = (longint'(rate) << (FREQ_FRAC + FRAC_BITS)) / spacing;
                    if (quot > FREQ_MAX)
                        quot = FREQ_MAX;
                end
                r.ivalid = 1'b1;
                r.freq   = quot[FREQ_W-1:0];
                r.mid    = POS_W'(((last_edge + pos_now) >> 1) & EDGE_MASK);
                if (intervals != COUNT_MAX)
                    intervals = intervals + 1'b1;
            end
            last_edge = pos_now;
            seen_edge = 1'b1;
        end
        last_sample = cur;
        seen_sample = 1'b1;
        sample_pos  = sample_pos + 1'b1;
        if (is_cross || closes)
        begin
            r.crossing = is_cross;
            r.edge_pos = POS_W'(pos_now);
            r.count    = intervals;
            r.done     = closes;
            expected_results.push_back(r);
        end
        if (closes)
            clear_block();
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate        = RATE_RESET;
            errors_seen = 0;
            clear_block();
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                rate = cfg_wr_data;
            if (in_valid && in_ready)
                track_sample(sample, block_end);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item waiting for one");
                    errors_seen++;
                end
                else
                begin
                    crossing_result_t want;
                    want = expected_results.pop_front();
                    compare_field("crossing", want.crossing, crossing);
                    compare_field("edge_position", want.edge_pos, edge_position);
                    compare_field("interval_valid", want.ivalid, interval_valid);
                    compare_field("interval_frequency", want.freq, interval_frequency);
                    compare_field("interval_midpoint", want.mid, interval_midpoint);
                    compare_field("interval_count", want.count, interval_count);
                    compare_field("block_done", want.done, block_done);
                end
            end
            fail_count <= errors_seen;
            pending    <= expected_results.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Stimulus, idling and verdict for the negative-going zero-crossing interval estimator.
`timescale 1ns / 1ps
module testbench;
    import nzcr_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    // longest item is a later crossing, through both dividers; leave margin
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 75;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [RATE_W-1:0]          cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic                       out_valid;
    logic                       out_ready;
    logic                       crossing;
    logic [POS_W-1:0]           edge_position;
    logic                       interval_valid;
    logic [FREQ_W-1:0]          interval_frequency;
    logic [POS_W-1:0]           interval_midpoint;
    logic [COUNT_W-1:0]         interval_count;
    logic                       block_done;

    int fail_count;
    int pending;
    int cycle_count;
    bit calm;        // no idling on either side once set
    int stall_left;

    negative_zero_crossing_rate uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .sample             (sample),
        .block_end          (block_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .crossing           (crossing),
        .edge_position      (edge_position),
        .interval_valid     (interval_valid),
        .interval_frequency (interval_frequency),
        .interval_midpoint  (interval_midpoint),
        .interval_count     (interval_count),
        .block_done         (block_done)
    );

    crossing_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .sample             (sample),
        .block_end          (block_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .crossing           (crossing),
        .edge_position      (edge_position),
        .interval_valid     (interval_valid),
        .interval_frequency (interval_frequency),
        .interval_midpoint  (interval_midpoint),
        .interval_count     (interval_count),
        .block_done         (block_done),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Receiver: ready high most of the time, with random stall bursts.
    // Exactly one assignment to out_ready per edge.
    initial
    begin
        out_ready  <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0 && !calm)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = 0;
                if (!calm && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // on return so back-to-back items need no drop.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic closes);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= s;
        block_end <= closes;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Let every expected result come back, then give a trailing item with
    // no result time to finish before anything touches the register.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Two crossings as close as the sign rule allows: largest fraction on the
    // first edge, smallest on the second. Gives the highest frequency.
    task automatic push_tight_pair();
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sh8000, 1'b1);
    endtask

    // Random blocks: mostly square-ish waves with random half periods and
    // amplitudes, some stray zeros and extremes; a share of pure noise blocks.
    task automatic push_random_blocks(input int budget);
        int                         sent;
        int                         len;
        int                         i;
        int                         run;
        int                         amp;
        logic                       high_half;
        logic                       noisy;
        logic signed [SAMPLE_W-1:0] s;
        sent = 0;
        while (sent < budget)
        begin
            len       = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90)
                                                    : $urandom_range(1, 40);
            noisy     = ($urandom_range(0, 4) == 0);
            amp       = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(1, 2000);
            high_half = 1'($urandom_range(0, 1));
            run       = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
            begin
                if (noisy)
                    s = SAMPLE_W'($urandom);
                else
                begin
                    if (run == 0)
                    begin
                        high_half = !high_half;
                        run       = $urandom_range(1, 6);
                    end
                    run--;
                    case ($urandom_range(0, 15))
                        0:       s = '0;
                        1:       s = high_half ? 16'sh7FFF : -16'sh8000;
                        default: s = high_half ? SAMPLE_W'($urandom_range(1, amp))
                                               : SAMPLE_W'(-$urandom_range(1, amp));
                    endcase
                end
                push_sample(s, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        logic [RATE_W-1:0] rates[6];
        int                p;

        rst_n       = 1'b0;
        calm        = 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        sample      <= '0;
        block_end   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset rate.
        // Negative first sample cannot cross; full-scale crossing; smallest
        // crossing; zeros between the signs never count; crossing on the
        // block's last sample.
        push_sample(-16'sd100, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd7, 1'b0);
        push_sample(16'sd5, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(16'sd200, 1'b0);
        push_sample(-16'sd20, 1'b1);
        // single-sample block: no crossing, count stays zero
        push_sample(16'sd50, 1'b1);
        // positive end of the last block must not pair with this negative start
        push_sample(-16'sd9, 1'b0);
        push_sample(16'sd9, 1'b0);
        push_sample(16'sd0, 1'b1);
        // first edge of a block lands on its closing sample
        push_sample(16'sd300, 1'b0);
        push_sample(-16'sd300, 1'b1);
        push_random_blocks(60);

        // Rate phases: zero, both ends of the range, all ones (the largest rate),
        // a random rate, and a calm final phase.
        rates[0] = '0;
        rates[1] = 18'd1;
        rates[2] = 18'd200000;
        rates[3] = '1;
        rates[4] = RATE_W'($urandom_range(1, 200000));
        rates[5] = 18'd8000;
        for (p = 0; p < 6; p++)
        begin
            drain_results();
            if (p == 5)
                calm = 1'b1;
            write_rate(rates[p]);
            push_tight_pair();
            push_random_blocks(PHASE_ITEMS);
        end

        drain_results();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
